### sv/bqy_pkg.sv
package bqy_pkg;

    typedef struct packed {
        logic [11:0] sample_top_left;
        logic [11:0] sample_top_right;
        logic [11:0] sample_bottom_left;
        logic [11:0] sample_bottom_right;
    } quad_in_t;

    typedef struct packed {
        logic [9:0] out_top_left;
        logic [9:0] out_top_right;
        logic [9:0] out_bottom_left;
        logic [9:0] out_bottom_right;
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } quad_out_t;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_SOURCE_ORDER = 2'd0;
    localparam logic [1:0] REG_SOURCE_DEPTH = 2'd1;
    localparam logic [1:0] REG_TARGET_ORDER = 2'd2;
    localparam logic [1:0] REG_TARGET_KIND  = 2'd3;

    localparam logic [1:0] DEPTH_8    = 2'd0;
    localparam logic [1:0] DEPTH_10   = 2'd1;
    localparam logic [1:0] DEPTH_12   = 2'd2;
    localparam logic [1:0] DEPTH_RSVD = 2'd3;

    localparam logic [1:0] KIND_BAYER8  = 2'd0;
    localparam logic [1:0] KIND_BAYER10 = 2'd1;
    localparam logic [1:0] KIND_YUV     = 2'd2;
    localparam logic [1:0] KIND_RSVD    = 2'd3;

    // colour slots: 0 R, 1 Gr, 2 Gb, 3 B
    localparam logic [1:0] COL_R  = 2'd0;
    localparam logic [1:0] COL_GR = 2'd1;
    localparam logic [1:0] COL_GB = 2'd2;
    localparam logic [1:0] COL_B  = 2'd3;

    localparam logic [8:0]  COEF_Y_R  = 9'd257;
    localparam logic [8:0]  COEF_Y_G  = 9'd504;
    localparam logic [8:0]  COEF_Y_B  = 9'd98;
    localparam logic [8:0]  COEF_U_R  = 9'd148;
    localparam logic [8:0]  COEF_U_G  = 9'd291;
    localparam logic [8:0]  COEF_U_B  = 9'd439;
    localparam logic [8:0]  COEF_V_R  = 9'd439;
    localparam logic [8:0]  COEF_V_G  = 9'd368;
    localparam logic [8:0]  COEF_V_B  = 9'd71;
    localparam logic [7:0]  OFFSET_Y  = 8'd16;
    localparam logic [7:0]  OFFSET_C  = 8'd128;

    // x / 4000 == (x * ceil(2^32 / 4000)) >> 32 for all |x| < 2^20
    localparam int          RECIP_SHIFT = 32;
    localparam logic [20:0] RECIP_MULT  = 21'd1073742;

    typedef logic [9:0] colour_t;
    typedef colour_t [3:0] quad_col_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [1:0] target_order;
        quad_col_t  col;
    } s1_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        quad_col_t          bayer;
        logic [19:0]        y_sum;
        logic signed [19:0] u_sum;
        logic signed [19:0] v_sum;
    } s2_t;

    typedef struct packed {
        logic adv_mid;
        logic adv_out;
    } scale_ctl_t;

    // Colour slot at a raster position for a Bayer order. The mapping is its
    // own inverse, so it also gives the raster position of a colour slot.
    function automatic logic [1:0] colour_at(input logic [1:0] order, input logic [1:0] pos);
        return order ^ pos;
    endfunction

endpackage

### sv/bqy_unpack.sv
module bqy_unpack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_fire,
    input  bqy_pkg::quad_in_t in_data,
    input  logic [1:0]        source_order,
    input  logic [1:0]        source_depth,
    input  logic [1:0]        target_order,
    input  logic [1:0]        target_kind,
    output bqy_pkg::s1_t      s1
);
    import bqy_pkg::*;

    logic [11:0] smp [4];
    colour_t     norm [4];
    s1_t         s1_reg;
    s1_t         s1_next;

    assign smp[0] = in_data.sample_top_left;
    assign smp[1] = in_data.sample_top_right;
    assign smp[2] = in_data.sample_bottom_left;
    assign smp[3] = in_data.sample_bottom_right;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            case (source_depth)
                DEPTH_8:  norm[p] = {smp[p][7:0], 2'b00};
                DEPTH_10: norm[p] = smp[p][9:0];
                default:  norm[p] = smp[p][11:2];
            endcase
        end
    end

    always_comb
    begin
        s1_next.valid        = in_fire && (source_depth != DEPTH_RSVD)
                               && (target_kind != KIND_RSVD);
        s1_next.kind         = target_kind;
        s1_next.target_order = target_order;
        for (int c = 0; c < 4; c++)
        begin
            s1_next.col[c] = norm[colour_at(source_order, 2'(c))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

    a_no_reserved_kind: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid |-> s1_reg.kind != KIND_RSVD)
        else $error("reserved destination entered the pipeline");

endmodule

### sv/bqy_matrix.sv
module bqy_matrix (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  bqy_pkg::s1_t s1,
    output bqy_pkg::s2_t s2
);
    import bqy_pkg::*;

    logic [10:0]        g_pair;
    logic [19:0]        r_u;
    logic [19:0]        g_u;
    logic [19:0]        b_u;
    logic signed [20:0] r_s;
    logic signed [20:0] g_s;
    logic signed [20:0] b_s;
    colour_t            pick;
    s2_t                s2_reg;
    s2_t                s2_next;

    assign g_pair = {1'b0, s1.col[COL_GR]} + {1'b0, s1.col[COL_GB]};
    assign r_u    = {10'd0, s1.col[COL_R]};
    assign g_u    = {10'd0, g_pair[10:1]};
    assign b_u    = {10'd0, s1.col[COL_B]};
    assign r_s    = signed'({1'b0, r_u});
    assign g_s    = signed'({1'b0, g_u});
    assign b_s    = signed'({1'b0, b_u});

    always_comb
    begin
        pick          = '0;
        s2_next.valid = s1.valid;
        s2_next.kind  = s1.kind;
        s2_next.y_sum = r_u * {11'd0, COEF_Y_R} + g_u * {11'd0, COEF_Y_G}
                        + b_u * {11'd0, COEF_Y_B};
        s2_next.u_sum = 20'(b_s * signed'({12'd0, COEF_U_B})
                        - r_s * signed'({12'd0, COEF_U_R})
                        - g_s * signed'({12'd0, COEF_U_G}));
        s2_next.v_sum = 20'(r_s * signed'({12'd0, COEF_V_R})
                        - g_s * signed'({12'd0, COEF_V_G})
                        - b_s * signed'({12'd0, COEF_V_B}));
        for (int p = 0; p < 4; p++)
        begin
            pick = s1.col[colour_at(s1.target_order, 2'(p))];
            case (s1.kind)
                KIND_BAYER8:  s2_next.bayer[p] = {2'b00, pick[9:2]};
                KIND_BAYER10: s2_next.bayer[p] = pick;
                default:      s2_next.bayer[p] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

### sv/bqy_scale.sv
module bqy_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  bqy_pkg::scale_ctl_t ctl,
    input  bqy_pkg::s2_t        s2,
    output logic                mid_valid,
    output logic                out_valid,
    output bqy_pkg::quad_out_t  out_data
);
    import bqy_pkg::*;

    localparam int PW = 41;

    logic        s3_valid_reg;
    logic [1:0]  s3_kind_reg;
    quad_col_t   s3_bayer_reg;
    logic [PW-1:0] s3_py_reg;
    logic [PW-1:0] s3_pu_reg;
    logic [PW-1:0] s3_pv_reg;
    logic        s3_nu_reg;
    logic        s3_nv_reg;

    logic [19:0] mag_u;
    logic [19:0] mag_v;
    logic [8:0]  q_y;
    logic [8:0]  q_u;
    logic [8:0]  q_v;

    logic      out_valid_reg;
    quad_out_t out_data_reg;
    quad_out_t out_data_next;

    function automatic logic [7:0] offset_clamp(input logic [7:0] base, input logic [8:0] q,
                                                input logic neg);
        logic signed [10:0] t;
        begin
            if (neg)
            begin
                t = signed'({3'd0, base}) - signed'({2'd0, q});
            end
            else
            begin
                t = signed'({3'd0, base}) + signed'({2'd0, q});
            end
            if (t < 0)
            begin
                return 8'd0;
            end
            else if (t > 11'sd255)
            begin
                return 8'd255;
            end
            return t[7:0];
        end
    endfunction

    // divide magnitudes, apply sign afterwards so the quotient truncates toward zero
    assign mag_u = s2.u_sum[19] ? 20'(-s2.u_sum) : s2.u_sum;
    assign mag_v = s2.v_sum[19] ? 20'(-s2.v_sum) : s2.v_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (ctl.adv_mid)
        begin
            s3_valid_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_mid)
        begin
            s3_kind_reg  <= s2.kind;
            s3_bayer_reg <= s2.bayer;
            s3_py_reg    <= {21'd0, s2.y_sum} * {20'd0, RECIP_MULT};
            s3_pu_reg    <= {21'd0, mag_u} * {20'd0, RECIP_MULT};
            s3_pv_reg    <= {21'd0, mag_v} * {20'd0, RECIP_MULT};
            s3_nu_reg    <= s2.u_sum[19];
            s3_nv_reg    <= s2.v_sum[19];
        end
    end

    assign q_y = s3_py_reg[RECIP_SHIFT +: 9];
    assign q_u = s3_pu_reg[RECIP_SHIFT +: 9];
    assign q_v = s3_pv_reg[RECIP_SHIFT +: 9];

    always_comb
    begin
        out_data_next.out_top_left     = s3_bayer_reg[0];
        out_data_next.out_top_right    = s3_bayer_reg[1];
        out_data_next.out_bottom_left  = s3_bayer_reg[2];
        out_data_next.out_bottom_right = s3_bayer_reg[3];
        if (s3_kind_reg == KIND_YUV)
        begin
            out_data_next.luma        = offset_clamp(OFFSET_Y, q_y, 1'b0);
            out_data_next.chroma_blue = offset_clamp(OFFSET_C, q_u, s3_nu_reg);
            out_data_next.chroma_red  = offset_clamp(OFFSET_C, q_v, s3_nv_reg);
        end
        else
        begin
            out_data_next.luma        = '0;
            out_data_next.chroma_blue = '0;
            out_data_next.chroma_red  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.adv_out)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign mid_valid = s3_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.out_top_left != 0 || out_data_reg.out_top_right != 0
            || out_data_reg.out_bottom_left != 0 || out_data_reg.out_bottom_right != 0)
        |-> out_data_reg.luma == 0 && out_data_reg.chroma_blue == 0
            && out_data_reg.chroma_red == 0)
        else $error("Bayer and YUV fields both set");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.adv_mid |=> s3_valid_reg && $stable(s3_py_reg) && $stable(s3_bayer_reg))
        else $error("stage 3 lost a held transaction");

endmodule

### sv/bayer_quad_reorder_to_yuv_core.sv
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ---------------------------------
// in       input      in_valid / in_stall    in_data  (bqy_pkg::quad_in_t)
// out      output     out_valid / out_stall  out_data (bqy_pkg::quad_out_t)
// cfg      input      APB psel/penable/...   four 2-bit registers at 4*i
//
// One quad per clock while out_stall is low; data passes four register
// stages from acceptance to out_valid (unpack, dot products, reciprocal
// multiply, offset/clamp with output register).
// A stalled stage holds; empty stages ahead of a stall still fill, so
// in_stall rises only when all four stages hold data and out_stall is high.
// Reserved depth or destination codes drop the transaction at stage 1.
// rst_n clears all valid bits and restores register defaults.
module bayer_quad_reorder_to_yuv_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bqy_pkg::quad_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bqy_pkg::quad_out_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bqy_pkg::*;

    logic [1:0] source_order_reg;
    logic [1:0] source_depth_reg;
    logic [1:0] target_order_reg;
    logic [1:0] target_kind_reg;
    logic       cfg_write;

    s1_t        s1;
    s2_t        s2;
    scale_ctl_t sctl;
    logic       mid_valid;
    logic       adv1;
    logic       adv2;
    logic       in_fire;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_order_reg <= 2'd0;
            source_depth_reg <= DEPTH_10;
            target_order_reg <= 2'd0;
            target_kind_reg  <= KIND_BAYER10;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SOURCE_ORDER: source_order_reg <= pwdata[1:0];
                REG_SOURCE_DEPTH: source_depth_reg <= pwdata[1:0];
                REG_TARGET_ORDER: target_order_reg <= pwdata[1:0];
                REG_TARGET_KIND:  target_kind_reg  <= pwdata[1:0];
                default:          source_order_reg <= source_order_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SOURCE_ORDER: prdata = {30'd0, source_order_reg};
            REG_SOURCE_DEPTH: prdata = {30'd0, source_depth_reg};
            REG_TARGET_ORDER: prdata = {30'd0, target_order_reg};
            REG_TARGET_KIND:  prdata = {30'd0, target_kind_reg};
            default:          prdata = '0;
        endcase
    end

    // advance a stage when it is empty or the one after it advances
    assign sctl.adv_out = !out_valid || !out_stall;
    assign sctl.adv_mid = !mid_valid || sctl.adv_out;
    assign adv2         = !s2.valid || sctl.adv_mid;
    assign adv1         = !s1.valid || adv2;
    assign in_stall     = !adv1;
    assign in_fire      = in_valid && adv1;

    bqy_unpack u_unpack (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv1),
        .in_fire      (in_fire),
        .in_data      (in_data),
        .source_order (source_order_reg),
        .source_depth (source_depth_reg),
        .target_order (target_order_reg),
        .target_kind  (target_kind_reg),
        .s1           (s1)
    );

    bqy_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv2),
        .s1    (s1),
        .s2    (s2)
    );

    bqy_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sctl),
        .s2        (s2),
        .mid_valid (mid_valid),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && mid_valid && s2.valid && s1.valid)
        else $error("input stalled with room in the pipeline");

endmodule
